// ===== sv/acev_pkg.sv =====
// Shared types, codes and defaults for the alarm condition evaluator.
`timescale 1ns / 1ps
`default_nettype none
package acev_pkg;

    localparam int RULES_DEF          = 16;
    localparam int CONDS_PER_RULE_DEF = 4;
    localparam int VAR_SLOTS_DEF      = 32;
    localparam int MAX_OUT            = 16;

    localparam logic [15:0] UNUSED_ID = 16'hFFFF;

    localparam logic [1:0] ACT_VAR  = 2'd0;
    localparam logic [1:0] ACT_HDR  = 2'd1;
    localparam logic [1:0] ACT_COND = 2'd2;
    localparam logic [1:0] ACT_EVAL = 2'd3;

    localparam logic [1:0] OP_GT    = 2'd0;
    localparam logic [1:0] OP_LT    = 2'd1;
    localparam logic [1:0] OP_EQ    = 2'd2;
    localparam logic [1:0] OP_NEVER = 2'd3;

    localparam logic [1:0] MODE_AND = 2'd0;
    localparam logic [1:0] MODE_OR  = 2'd1;

    localparam logic [1:0] CFG_VAR_COUNT  = 2'd0;
    localparam logic [1:0] CFG_TASK_COUNT = 2'd1;
    localparam logic [1:0] CFG_MAX_TRIG   = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         task_index;
        logic [1:0]         cond_index;
        logic [4:0]         var_slot;
        logic [7:0]         key_id;
        logic [15:0]        key_leaf_addr;
        logic [7:0]         key_leaf_port;
        logic signed [31:0] number_value;
        logic [1:0]         compare_op;
        logic [15:0]        rule_id;
        logic [2:0]         cond_total;
        logic [1:0]         combine_mode;
    } in_item_t;

    typedef struct packed {
        logic [15:0] alarm_id;
        logic        hit;
        logic        last;
        logic [4:0]  trigger_total;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RULE_RD,
        ST_RULE_CHK,
        ST_COND_RD,
        ST_COND_MATCH,
        ST_COND_CMP,
        ST_FIRE,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== sv/acev_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module acev_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/alarm_condition_evaluator.sv =====
// Top level of the alarm condition evaluator: tables, sequencer and output register.
`timescale 1ns / 1ps
`default_nettype none
// Variable, rule and condition writes are taken from the idle state and give no
// result. An evaluation is run by a sequencer that reads the rule header RAM
// and then the condition RAM one condition at a time; every condition passes
// three steps (condition read, parallel key match with value read, compare),
// every visited rule a header read and a check, every trigger a fire step and
// the end a last bound check and a done step, and a result may wait on a
// stalled output. One item is worked on at a time; the next request is taken
// once the sequencer is idle again, while the last result may still wait in
// the output register. Table entries start at their reset contents through
// valid bits, so no clearing pass follows reset.
module alarm_condition_evaluator #(
    parameter int RULES          = acev_pkg::RULES_DEF,
    parameter int CONDS_PER_RULE = acev_pkg::CONDS_PER_RULE_DEF,
    parameter int VAR_SLOTS      = acev_pkg::VAR_SLOTS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire acev_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output acev_pkg::out_item_t      out_data,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [5:0]          cfg_data
);

    import acev_pkg::*;

    localparam int CONDS = RULES * CONDS_PER_RULE;
    localparam int RW    = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int RCW   = $clog2(RULES + 1);
    localparam int CW    = (CONDS > 1) ? $clog2(CONDS) : 1;
    localparam int CCW   = $clog2(CONDS_PER_RULE + 1);
    localparam int VW    = (VAR_SLOTS > 1) ? $clog2(VAR_SLOTS) : 1;
    localparam int HW    = 21;
    localparam int KW    = 66;

    // configuration
    logic [5:0] var_count_reg;
    logic [4:0] task_count_reg;
    logic [4:0] max_trig_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var_count_reg  <= '0;
            task_count_reg <= '0;
            max_trig_reg   <= 5'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VAR_COUNT:  var_count_reg  <= cfg_data;
                CFG_TASK_COUNT: task_count_reg <= cfg_data[4:0];
                CFG_MAX_TRIG:   max_trig_reg   <= cfg_data[4:0];
                default:        ;
            endcase
        end
    end

    logic [7:0] rules_lim;
    logic [8:0] vars_lim;
    logic [4:0] trig_lim;

    assign rules_lim = (8'(task_count_reg) > 8'(RULES)) ? 8'(RULES) : 8'(task_count_reg);
    assign vars_lim  = (9'(var_count_reg) > 9'(VAR_SLOTS)) ? 9'(VAR_SLOTS)
                                                           : 9'(var_count_reg);
    assign trig_lim  = (max_trig_reg > 5'(MAX_OUT)) ? 5'(MAX_OUT) : max_trig_reg;

    // sequencer registers
    state_t          state_reg, state_next;
    logic [RCW-1:0]  r_reg, r_next;
    logic [CCW-1:0]  c_reg, c_next;
    logic [CCW-1:0]  n_reg, n_next;
    logic [1:0]      mode_reg, mode_next;
    logic [15:0]     id_reg, id_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic            pend_v_reg, pend_v_next;
    logic [15:0]     pend_id_reg, pend_id_next;
    logic [4:0]      pend_tot_reg, pend_tot_next;
    logic            found_reg, found_next;
    logic [1:0]      op_reg, op_next;
    logic [31:0]     thr_reg, thr_next;
    logic            out_valid_reg, out_valid_next;
    out_item_t       out_reg, out_next;

    // table access
    logic            var_we, hdr_we, cond_we;
    logic            hdr_re, cond_re, var_re;
    logic [RW-1:0]   hdr_waddr;
    logic [CW-1:0]   cond_waddr, cond_raddr;
    logic [VW-1:0]   var_waddr, var_raddr;
    logic [HW-1:0]   hdr_rdata, hdr_word;
    logic [KW-1:0]   cond_rdata, cond_word;
    logic [31:0]     var_rdata, var_val;
    logic [31:0]     in_key;

    logic            hdr_vld_reg  [RULES];
    logic            cond_vld_reg [CONDS];
    logic            var_vld_reg  [VAR_SLOTS];
    logic [31:0]     var_key_reg  [VAR_SLOTS];
    logic            hdr_rv_reg, cond_rv_reg, var_rv_reg;

    assign in_key    = {in_data.key_id, in_data.key_leaf_addr, in_data.key_leaf_port};
    assign hdr_waddr = RW'(in_data.task_index);
    assign var_waddr = VW'(in_data.var_slot);
    assign cond_waddr = CW'(int'(in_data.task_index) * CONDS_PER_RULE
                            + int'(in_data.cond_index));
    assign cond_raddr = CW'(int'(r_reg[RW-1:0]) * CONDS_PER_RULE + int'(c_reg));

    acev_ram #(.WIDTH(HW), .DEPTH(RULES)) u_hdr_ram (
        .clk   (clk),
        .we    (hdr_we),
        .waddr (hdr_waddr),
        .wdata ({in_data.rule_id, in_data.cond_total, in_data.combine_mode}),
        .re    (hdr_re),
        .raddr (r_reg[RW-1:0]),
        .rdata (hdr_rdata)
    );

    acev_ram #(.WIDTH(KW), .DEPTH(CONDS)) u_cond_ram (
        .clk   (clk),
        .we    (cond_we),
        .waddr (cond_waddr),
        .wdata ({in_key, in_data.compare_op, in_data.number_value}),
        .re    (cond_re),
        .raddr (cond_raddr),
        .rdata (cond_rdata)
    );

    acev_ram #(.WIDTH(32), .DEPTH(VAR_SLOTS)) u_var_ram (
        .clk   (clk),
        .we    (var_we),
        .waddr (var_waddr),
        .wdata (in_data.number_value),
        .re    (var_re),
        .raddr (var_raddr),
        .rdata (var_rdata)
    );

    // valid bits stand in for the reset contents of each table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RULES; i++)
            begin
                hdr_vld_reg[i] <= 1'b0;
            end
            for (int i = 0; i < CONDS; i++)
            begin
                cond_vld_reg[i] <= 1'b0;
            end
            for (int i = 0; i < VAR_SLOTS; i++)
            begin
                var_vld_reg[i] <= 1'b0;
                var_key_reg[i] <= '0;
            end
            hdr_rv_reg  <= 1'b0;
            cond_rv_reg <= 1'b0;
            var_rv_reg  <= 1'b0;
        end
        else
        begin
            if (hdr_we)
            begin
                hdr_vld_reg[hdr_waddr] <= 1'b1;
            end
            if (cond_we)
            begin
                cond_vld_reg[cond_waddr] <= 1'b1;
            end
            if (var_we)
            begin
                var_vld_reg[var_waddr] <= 1'b1;
                var_key_reg[var_waddr] <= in_key;
            end
            if (hdr_re)
            begin
                hdr_rv_reg <= hdr_vld_reg[r_reg[RW-1:0]];
            end
            if (cond_re)
            begin
                cond_rv_reg <= cond_vld_reg[cond_raddr];
            end
            if (var_re)
            begin
                var_rv_reg <= var_vld_reg[var_raddr];
            end
        end
    end

    assign hdr_word  = hdr_rv_reg ? hdr_rdata : {UNUSED_ID, 3'd0, MODE_AND};
    assign cond_word = cond_rv_reg ? cond_rdata : {32'd0, OP_NEVER, 32'd0};
    assign var_val   = var_rv_reg ? var_rdata : 32'd0;

    // lowest matching slot below the variable count
    logic match_any;
    always_comb
    begin
        match_any = 1'b0;
        var_raddr = '0;
        for (int s = VAR_SLOTS - 1; s >= 0; s--)
        begin
            if (var_key_reg[s] == cond_word[65:34] && s < int'(vars_lim))
            begin
                match_any = 1'b1;
                var_raddr = VW'(s);
            end
        end
    end

    logic       cmp_ok;
    logic [4:0] n_sat;
    logic       out_free;
    logic       in_take;

    always_comb
    begin
        case (op_reg)
            OP_GT:   cmp_ok = $signed(var_val) > $signed(thr_reg);
            OP_LT:   cmp_ok = $signed(var_val) < $signed(thr_reg);
            OP_EQ:   cmp_ok = var_val == thr_reg;
            default: cmp_ok = 1'b0;
        endcase
    end

    assign n_sat    = (5'(hdr_word[4:2]) > 5'(CONDS_PER_RULE)) ? 5'(CONDS_PER_RULE)
                                                               : 5'(hdr_word[4:2]);
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        n_next         = n_reg;
        mode_next      = mode_reg;
        id_next        = id_reg;
        cnt_next       = cnt_reg;
        pend_v_next    = pend_v_reg;
        pend_id_next   = pend_id_reg;
        pend_tot_next  = pend_tot_reg;
        found_next     = found_reg;
        op_next        = op_reg;
        thr_next       = thr_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        var_we         = 1'b0;
        hdr_we         = 1'b0;
        cond_we        = 1'b0;
        hdr_re         = 1'b0;
        cond_re        = 1'b0;
        var_re         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    case (in_data.action)
                        ACT_VAR:
                            var_we = 9'(in_data.var_slot) < 9'(VAR_SLOTS);
                        ACT_HDR:
                            hdr_we = 8'(in_data.task_index) < 8'(RULES);
                        ACT_COND:
                            cond_we = 8'(in_data.task_index) < 8'(RULES)
                                   && 5'(in_data.cond_index) < 5'(CONDS_PER_RULE);
                        default:
                        begin
                            r_next      = '0;
                            cnt_next    = '0;
                            pend_v_next = 1'b0;
                            state_next  = ST_RULE_RD;
                        end
                    endcase
                end
            end
            ST_RULE_RD:
            begin
                if (8'(r_reg) >= rules_lim || cnt_reg >= trig_lim)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    hdr_re     = 1'b1;
                    state_next = ST_RULE_CHK;
                end
            end
            ST_RULE_CHK:
            begin
                id_next   = hdr_word[20:5];
                mode_next = hdr_word[1:0];
                n_next    = CCW'(n_sat);
                c_next    = '0;
                // skip unused rules, empty rules and unknown modes
                if (hdr_word[20:5] == UNUSED_ID || n_sat == 5'd0 || hdr_word[1])
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = ST_RULE_RD;
                end
                else
                begin
                    state_next = ST_COND_RD;
                end
            end
            ST_COND_RD:
            begin
                cond_re    = 1'b1;
                state_next = ST_COND_MATCH;
            end
            ST_COND_MATCH:
            begin
                var_re     = 1'b1;
                found_next = match_any;
                op_next    = cond_word[33:32];
                thr_next   = cond_word[31:0];
                state_next = ST_COND_CMP;
            end
            ST_COND_CMP:
            begin
                if (mode_reg == MODE_AND && (!found_reg || !cmp_ok))
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = ST_RULE_RD;
                end
                else if (mode_reg == MODE_OR && found_reg && cmp_ok)
                begin
                    state_next = ST_FIRE;
                end
                else if (5'(c_reg) + 5'd1 == 5'(n_reg))
                begin
                    if (mode_reg == MODE_AND)
                    begin
                        state_next = ST_FIRE;
                    end
                    else
                    begin
                        r_next     = r_reg + 1'b1;
                        state_next = ST_RULE_RD;
                    end
                end
                else
                begin
                    c_next     = c_reg + 1'b1;
                    state_next = ST_COND_RD;
                end
            end
            ST_FIRE:
            begin
                // hold the newest hit back until it is known whether it is the last
                if (!pend_v_reg || out_free)
                begin
                    if (pend_v_reg)
                    begin
                        out_next       = '{pend_id_reg, 1'b1, 1'b0, pend_tot_reg};
                        out_valid_next = 1'b1;
                    end
                    pend_v_next   = 1'b1;
                    pend_id_next  = id_reg;
                    pend_tot_next = cnt_reg + 5'd1;
                    cnt_next      = cnt_reg + 5'd1;
                    r_next        = r_reg + 1'b1;
                    state_next    = ST_RULE_RD;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    if (pend_v_reg)
                    begin
                        out_next = '{pend_id_reg, 1'b1, 1'b1, pend_tot_reg};
                    end
                    else
                    begin
                        out_next = '{16'd0, 1'b0, 1'b1, 5'd0};
                    end
                    out_valid_next = 1'b1;
                    pend_v_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            r_reg         <= '0;
            c_reg         <= '0;
            cnt_reg       <= '0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            cnt_reg       <= cnt_next;
            pend_v_reg    <= pend_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        mode_reg     <= mode_next;
        id_reg       <= id_next;
        pend_id_reg  <= pend_id_next;
        pend_tot_reg <= pend_tot_next;
        found_reg    <= found_next;
        op_reg       <= op_next;
        thr_reg      <= thr_next;
        out_reg      <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

// ===== sv/acev_chk.sv =====
// Port-level checks for the alarm condition evaluator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module acev_chk (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire acev_pkg::out_item_t out_data
);

    import acev_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |->
            out_data.last && out_data.trigger_total == 5'd0 && out_data.alarm_id == 16'd0)
        else $error("empty result malformed");

    a_hit_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hit |->
            out_data.trigger_total != 5'd0 && out_data.trigger_total <= 5'(MAX_OUT))
        else $error("trigger count out of range");

    a_non_last_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> out_data.hit)
        else $error("non-final result without hit");

endmodule

bind alarm_condition_evaluator acev_chk u_acev_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire

// ===== verif/alarm_condition_evaluator_tb.sv =====
// Self-checking testbench for the alarm condition evaluator: table writes, evaluations, config sweeps.
`timescale 1ns / 1ps
module alarm_condition_evaluator_tb;
    import acev_pkg::*;

    localparam int DRAIN_CYCLES = 300;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_VAR_COUNT;
    logic [5:0] cfg_data = '0;

    alarm_condition_evaluator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // shadow copy of the tables and registers
    logic [31:0] sh_var_key [VAR_SLOTS_DEF];
    logic [31:0] sh_var_num [VAR_SLOTS_DEF];
    logic [15:0] sh_rule_id [RULES_DEF];
    logic [2:0]  sh_rule_total [RULES_DEF];
    logic [1:0]  sh_rule_mode [RULES_DEF];
    logic [31:0] sh_cond_key [RULES_DEF*CONDS_PER_RULE_DEF];
    logic [1:0]  sh_cond_op [RULES_DEF*CONDS_PER_RULE_DEF];
    logic [31:0] sh_cond_thr [RULES_DEF*CONDS_PER_RULE_DEF];
    int unsigned sh_var_count = 0;
    int unsigned sh_task_count = 0;
    int unsigned sh_max_trig = 16;

    in_item_t  pending_reqs[$];
    out_item_t expected_alarms[$];
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    logic        rx_hold = 1'b0;
    int unsigned errors = 0;
    int unsigned n_reqs = 0;
    int unsigned n_evals = 0;
    int unsigned n_hits = 0;
    int unsigned n_results = 0;

    logic [31:0] key_pool [8];

    function automatic int find_var(logic [31:0] key);
        int unsigned n;
        n = (sh_var_count > VAR_SLOTS_DEF) ? VAR_SLOTS_DEF : sh_var_count;
        for (int s = 0; s < n; s++)
            if (sh_var_key[s] == key)
                return s;
        return -1;
    endfunction

    function automatic bit rule_triggers(int r);
        int unsigned n;
        int          ci;
        int          s;
        bit          ok;
        logic signed [31:0] a;
        logic signed [31:0] b;
        n = sh_rule_total[r];
        if (n > CONDS_PER_RULE_DEF)
            n = CONDS_PER_RULE_DEF;
        if (n == 0 || (sh_rule_mode[r] != MODE_AND && sh_rule_mode[r] != MODE_OR))
            return 1'b0;
        for (int c = 0; c < n; c++)
        begin
            ci = r * CONDS_PER_RULE_DEF + c;
            s = find_var(sh_cond_key[ci]);
            if (s < 0)
            begin
                if (sh_rule_mode[r] == MODE_AND)
                    return 1'b0;
                continue;
            end
            a = sh_var_num[s];
            b = sh_cond_thr[ci];
            case (sh_cond_op[ci])
                OP_GT:   ok = a > b;
                OP_LT:   ok = a < b;
                OP_EQ:   ok = a == b;
                default: ok = 1'b0;
            endcase
            if (sh_rule_mode[r] == MODE_AND && !ok)
                return 1'b0;
            if (sh_rule_mode[r] == MODE_OR && ok)
                return 1'b1;
        end
        return sh_rule_mode[r] == MODE_AND;
    endfunction

    // apply one accepted request to the shadow tables and queue its alarms
    function automatic void apply_request(in_item_t q);
        logic [31:0] key;
        logic [15:0] ids[$];
        int unsigned nrules;
        int unsigned lim;
        out_item_t   o;
        key = {q.key_id, q.key_leaf_addr, q.key_leaf_port};
        case (q.action)
            ACT_VAR:
            begin
                sh_var_key[q.var_slot] = key;
                sh_var_num[q.var_slot] = q.number_value;
            end
            ACT_HDR:
            begin
                sh_rule_id[q.task_index] = q.rule_id;
                sh_rule_total[q.task_index] = q.cond_total;
                sh_rule_mode[q.task_index] = q.combine_mode;
            end
            ACT_COND:
            begin
                sh_cond_key[q.task_index*CONDS_PER_RULE_DEF + q.cond_index] = key;
                sh_cond_op[q.task_index*CONDS_PER_RULE_DEF + q.cond_index] = q.compare_op;
                sh_cond_thr[q.task_index*CONDS_PER_RULE_DEF + q.cond_index] = q.number_value;
            end
            default:
            begin
                n_evals++;
                nrules = (sh_task_count > RULES_DEF) ? RULES_DEF : sh_task_count;
                lim = (sh_max_trig > MAX_OUT) ? MAX_OUT : sh_max_trig;
                for (int r = 0; r < nrules && ids.size() < lim; r++)
                    if (sh_rule_id[r] != UNUSED_ID && rule_triggers(r))
                        ids.push_back(sh_rule_id[r]);
                if (ids.size() == 0)
                begin
                    o = '0;
                    o.last = 1'b1;
                    expected_alarms.push_back(o);
                end
                for (int i = 0; i < ids.size(); i++)
                begin
                    o.alarm_id = ids[i];
                    o.hit = 1'b1;
                    o.last = (i == ids.size() - 1);
                    o.trigger_total = 5'(i + 1);
                    expected_alarms.push_back(o);
                    n_hits++;
                end
            end
        endcase
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                apply_request(in_data);
                n_reqs++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    in_data <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // alarm monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                if (expected_alarms.size() == 0)
                begin
                    $display("%0t: unexpected alarm, actual %h", $time, out_data);
                    errors++;
                end
                else
                begin
                    out_item_t e;
                    e = expected_alarms.pop_front();
                    if (e.alarm_id !== out_data.alarm_id || e.hit !== out_data.hit ||
                        e.last !== out_data.last || e.trigger_total !== out_data.trigger_total)
                    begin
                        $display("%0t: alarm mismatch, expected id %h hit %b last %b total %0d,",
                                 $time, e.alarm_id, e.hit, e.last, e.trigger_total);
                        $display("    actual id %h hit %b last %b total %0d",
                                 out_data.alarm_id, out_data.hit, out_data.last,
                                 out_data.trigger_total);
                        errors++;
                    end
                end
            end
            out_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic in_item_t noise_req();
        logic [127:0] raw;
        in_item_t     q;
        raw = {$urandom, $urandom, $urandom, $urandom};
        q = raw[$bits(in_item_t)-1:0];
        return q;
    endfunction

    function automatic void push_var(int slot, logic [31:0] key, logic [31:0] num);
        in_item_t q;
        q = noise_req();
        q.action = ACT_VAR;
        q.var_slot = 5'(slot);
        {q.key_id, q.key_leaf_addr, q.key_leaf_port} = key;
        q.number_value = num;
        pending_reqs.push_back(q);
    endfunction

    function automatic void push_hdr(int ti, logic [15:0] id, logic [2:0] total,
                                     logic [1:0] mode);
        in_item_t q;
        q = noise_req();
        q.action = ACT_HDR;
        q.task_index = 4'(ti);
        q.rule_id = id;
        q.cond_total = total;
        q.combine_mode = mode;
        pending_reqs.push_back(q);
    endfunction

    function automatic void push_cond(int ti, int ci, logic [31:0] key, logic [1:0] op,
                                      logic [31:0] thr);
        in_item_t q;
        q = noise_req();
        q.action = ACT_COND;
        q.task_index = 4'(ti);
        q.cond_index = 2'(ci);
        {q.key_id, q.key_leaf_addr, q.key_leaf_port} = key;
        q.compare_op = op;
        q.number_value = thr;
        pending_reqs.push_back(q);
    endfunction

    function automatic void push_eval();
        in_item_t q;
        q = noise_req();
        q.action = ACT_EVAL;
        pending_reqs.push_back(q);
    endfunction

    function automatic logic [31:0] pick_key();
        return ($urandom_range(9) < 8) ? key_pool[$urandom_range(7)] : $urandom;
    endfunction

    function automatic logic [31:0] pick_num();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            5: return $urandom;
            default: return $urandom_range(8) << 14;
        endcase
    endfunction

    task automatic wait_drained();
        do @(posedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_alarms.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [5:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_VAR_COUNT:  sh_var_count = val;
            CFG_TASK_COUNT: sh_task_count = val[4:0];
            default:        sh_max_trig = val[4:0];
        endcase
    endtask

    task automatic random_cfg(int round);
        case (round % 5)
            0: write_cfg(CFG_VAR_COUNT, 6'd32);
            1: write_cfg(CFG_VAR_COUNT, 6'd63);
            2: write_cfg(CFG_VAR_COUNT, 6'd0);
            default: write_cfg(CFG_VAR_COUNT, 6'($urandom_range(32)));
        endcase
        case (round % 6)
            0: write_cfg(CFG_TASK_COUNT, 6'd16);
            1: write_cfg(CFG_TASK_COUNT, 6'd31);
            2: write_cfg(CFG_TASK_COUNT, 6'd0);
            default: write_cfg(CFG_TASK_COUNT, 6'($urandom_range(1, 16)));
        endcase
        case (round % 7)
            0: write_cfg(CFG_MAX_TRIG, 6'd16);
            1: write_cfg(CFG_MAX_TRIG, 6'd31);
            2: write_cfg(CFG_MAX_TRIG, 6'd0);
            3: write_cfg(CFG_MAX_TRIG, 6'd1);
            default: write_cfg(CFG_MAX_TRIG, 6'($urandom_range(16)));
        endcase
    endtask

    initial
    begin
        logic [31:0] ka;
        logic [31:0] kb;
        logic [31:0] kc;
        int          round;
        for (int i = 0; i < VAR_SLOTS_DEF; i++)
        begin
            sh_var_key[i] = '0;
            sh_var_num[i] = '0;
        end
        for (int i = 0; i < RULES_DEF; i++)
        begin
            sh_rule_id[i] = UNUSED_ID;
            sh_rule_total[i] = '0;
            sh_rule_mode[i] = MODE_AND;
        end
        for (int i = 0; i < RULES_DEF*CONDS_PER_RULE_DEF; i++)
        begin
            sh_cond_key[i] = '0;
            sh_cond_op[i] = OP_NEVER;
            sh_cond_thr[i] = '0;
        end
        ka = 32'h0A12_3401;
        kb = 32'hFFFF_FFFF;
        kc = 32'h1234_5678;
        key_pool = '{ka, kb, kc, 32'h0, 32'h55AA_00FF, 32'h0100_0002, 32'hC0FF_EE03,
                     32'h7E00_8004};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // fresh block: nothing walked, so one empty alarm
        push_eval();
        wait_drained();
        write_cfg(CFG_VAR_COUNT, 6'd32);
        write_cfg(CFG_TASK_COUNT, 6'd16);

        push_var(0, ka, 32'h7FFF_FFFF);
        push_var(1, kb, 32'h8000_0000);
        push_var(2, ka, 32'd5);         // duplicate key: lower slot wins
        push_var(31, kc, 32'hFFFF_FFFF);
        push_hdr(0, 16'h0001, 3'd2, MODE_AND);
        push_cond(0, 0, ka, OP_GT, 32'h7FFF_FFFE);
        push_cond(0, 1, kb, OP_LT, 32'h8000_0001);
        push_hdr(1, 16'h0000, 3'd2, MODE_OR);
        push_cond(1, 0, 32'h5555_5555, OP_EQ, 32'h0);  // missing key, skipped under OR
        push_cond(1, 1, kc, OP_EQ, 32'hFFFF_FFFF);
        push_hdr(2, UNUSED_ID, 3'd1, MODE_AND);
        push_cond(2, 0, ka, OP_GT, 32'h0);
        push_hdr(3, 16'h0003, 3'd1, 2'd2);
        push_cond(3, 0, ka, OP_GT, 32'h0);
        push_hdr(4, 16'h0004, 3'd0, MODE_AND);
        push_hdr(5, 16'h0005, 3'd7, MODE_OR);
        push_cond(5, 3, kb, OP_NEVER, 32'h8000_0000);
        push_hdr(6, 16'h0006, 3'd1, MODE_AND);
        push_cond(6, 0, 32'h5555_5555, OP_GT, 32'h8000_0000);  // missing key fails AND
        push_hdr(7, 16'hFFFE, 3'd4, 2'd3);
        push_eval();

        for (round = 0; round < 32; round++)
        begin
            wait_drained();
            random_cfg(round);
            case ((round / 8) % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
                default: begin tx_idle_pct = 28; rx_stall_pct = 28; end
            endcase
            if (round == 4)
            begin
                // long receiver hold while requests keep coming
                rx_hold <= 1'b1;
                fork
                    begin
                        repeat (1500) @(posedge clk);
                        rx_hold <= 1'b0;
                    end
                join_none
            end
            repeat ($urandom_range(2, 5))
                push_var($urandom_range(31), pick_key(), pick_num());
            repeat ($urandom_range(1, 3))
            begin
                int ti;
                ti = $urandom_range(15);
                push_hdr(ti, ($urandom_range(9) == 0) ? UNUSED_ID : 16'($urandom),
                         ($urandom_range(9) == 0) ? 3'($urandom_range(7))
                                                  : 3'($urandom_range(1, 4)),
                         ($urandom_range(9) < 8) ? 2'($urandom_range(1))
                                                 : 2'($urandom_range(2, 3)));
                repeat ($urandom_range(1, 4))
                    push_cond(ti, $urandom_range(3), pick_key(), 2'($urandom_range(3)),
                              pick_num());
            end
            repeat ($urandom_range(1, 3))
                push_eval();
            if ($urandom_range(3) == 0)
                pending_reqs.push_back(noise_req());
        end

        wait_drained();
        $display("Run covered %0d requests, %0d evaluations, %0d alarms (%0d rule hits)",
                 n_reqs, n_evals, n_results, n_hits);
        $display("over four handshake pressure phases and %0d register settings", 3 * 32 + 2);
        if (errors == 0 && expected_alarms.size() == 0)
            $display("alarm_condition_evaluator regression: pass");
        else
            $display("alarm_condition_evaluator regression: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("alarm_condition_evaluator regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/acev_pkg.sv
sv/acev_ram.sv
sv/alarm_condition_evaluator.sv
sv/acev_chk.sv
verif/alarm_condition_evaluator_tb.sv
